// ----- rtl/utf8_code_table_reverse_lookup_core_defines.svh -----
// assertion macros used by the utf8 code table sequencer rtl
`ifndef UTF8_CODE_TABLE_REVERSE_LOOKUP_CORE_DEFINES_SVH
`define UTF8_CODE_TABLE_REVERSE_LOOKUP_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define UTF8CT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define UTF8CT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/utf8ct_pkg.sv -----
// types, codes and helpers for the utf8 code table
`timescale 1ns / 1ps

package utf8ct_pkg;

   localparam int TABLE_SIZE_DEF = 4096;
   localparam int CHAR_W         = 32;
   localparam int INDEX_W        = 16;
   localparam int INDEX_OUT_W    = 12;
   localparam int COUNT_W        = 13;
   localparam int SCAN_CMP_W     = 17;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 13'd8191;

   // lead byte thresholds for sequence length
   localparam logic [7:0] ONE_BYTE_LIMIT   = 8'd128;
   localparam logic [7:0] TWO_BYTE_LIMIT   = 8'd224;
   localparam logic [7:0] THREE_BYTE_LIMIT = 8'd240;

   // request codes
   localparam logic [1:0] REQ_WRITE       = 2'd0;
   localparam logic [1:0] REQ_READ        = 2'd1;
   localparam logic [1:0] REQ_LOOKUP      = 2'd2;
   localparam logic [1:0] REQ_LOOKUP_BYTE = 2'd3;

   // status codes
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_MISS  = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic [INDEX_W-1:0] index;
      logic [CHAR_W-1:0]  char_bytes;
   } req_item_type;

   typedef struct packed {
      logic [1:0]             status;
      logic [INDEX_OUT_W-1:0] index_out;
      logic [CHAR_W-1:0]      char_out;
   } rsp_item_type;

   // byte mask implied by the lead byte
   function automatic logic [CHAR_W-1:0] len_mask(input logic [7:0] lead);
      logic [CHAR_W-1:0] mask;
      if (lead < ONE_BYTE_LIMIT) begin
         mask = 32'h0000_00ff;
      end else if (lead < TWO_BYTE_LIMIT) begin
         mask = 32'h0000_ffff;
      end else if (lead < THREE_BYTE_LIMIT) begin
         mask = 32'h00ff_ffff;
      end else begin
         mask = 32'hffff_ffff;
      end
      return mask;
   endfunction

endpackage

// ----- rtl/utf8ct_ram.sv -----
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module utf8ct_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/utf8ct_ctrl.sv -----
// sequencer for table clear, write, read and reverse lookup scan
`timescale 1ns / 1ps
`include "utf8_code_table_reverse_lookup_core_defines.svh"

module utf8ct_ctrl
   import utf8ct_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  req_item_type                  req_data,
   input  logic                          out_free,
   output logic                          res_valid,
   output rsp_item_type                  res_data,
   output logic                          mem_we,
   output logic [$clog2(TABLE_SIZE)-1:0] mem_waddr,
   output logic [CHAR_W-1:0]             mem_wdata,
   output logic [$clog2(TABLE_SIZE)-1:0] mem_raddr,
   input  logic [CHAR_W-1:0]             mem_rdata
);

   localparam int AddrW = $clog2(TABLE_SIZE);
   localparam logic [AddrW-1:0] LastAddr = AddrW'(TABLE_SIZE - 1);
   localparam logic [SCAN_CMP_W-1:0] SizeExt = SCAN_CMP_W'(TABLE_SIZE);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [AddrW-1:0]       clear_addr_ff, clear_addr_in;
   logic [AddrW:0]         scan_addr_ff, scan_addr_in;
   logic                   pend_ff, pend_in;
   logic [AddrW-1:0]       pend_addr_ff, pend_addr_in;
   logic [CHAR_W-1:0]      key_ff, key_in;
   logic [CHAR_W-1:0]      mask_ff, mask_in;
   logic                   byte_ff, byte_in;
   rsp_item_type           res_ff, res_in;

   logic [CHAR_W-1:0]      req_mask;
   logic                   range_err;
   logic                   hit;
   logic                   issue;
   logic [SCAN_CMP_W-1:0]  scan_ext;
   logic [31:0]            hit_idx;

   always_comb begin
      req_mask  = len_mask(req_data.char_bytes[7:0]);
      range_err = SCAN_CMP_W'(req_data.index) >= SizeExt;
      scan_ext  = SCAN_CMP_W'(scan_addr_ff);
      issue     = (scan_ext < SCAN_CMP_W'(count_ff)) && (scan_ext < SizeExt);
      hit       = pend_ff && ((mem_rdata & mask_ff) == key_ff);
      hit_idx   = 32'(pend_addr_ff);

      state_in      = state_ff;
      count_in      = count_ff;
      clear_addr_in = clear_addr_ff;
      scan_addr_in  = scan_addr_ff;
      pend_in       = pend_ff;
      pend_addr_in  = pend_addr_ff;
      key_in        = key_ff;
      mask_in       = mask_ff;
      byte_in       = byte_ff;
      res_in        = res_ff;

      mem_we    = 1'b0;
      mem_waddr = clear_addr_ff;
      mem_wdata = '0;
      mem_raddr = req_data.index[AddrW-1:0];

      case (state_ff)
         ST_CLEAR: begin
            mem_we        = 1'b1;
            clear_addr_in = clear_addr_ff + 1'b1;
            if (clear_addr_ff == LastAddr) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '{status: STATUS_OK, index_out: '0, char_out: '0};
               case (req_data.req_type)
                  REQ_WRITE: begin
                     state_in = ST_DONE;
                     if (range_err) begin
                        res_in.status = STATUS_RANGE;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = req_data.index[AddrW-1:0];
                        mem_wdata = req_data.char_bytes & req_mask;
                        if (count_ff < COUNT_MAX) begin
                           count_in = count_ff + 1'b1;
                        end
                     end
                  end
                  REQ_READ: begin
                     if (range_err) begin
                        res_in.status = STATUS_RANGE;
                        state_in      = ST_DONE;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                     key_in       = req_data.char_bytes & req_mask;
                     mask_in      = req_mask;
                     byte_in      = (req_data.req_type == REQ_LOOKUP_BYTE);
                     scan_addr_in = '0;
                     pend_in      = 1'b0;
                     state_in     = ST_SCAN;
                  end
               endcase
            end
         end
         ST_READ: begin
            res_in.char_out = mem_rdata;
            state_in        = ST_DONE;
         end
         ST_SCAN: begin
            // one read issued per cycle, compared in the cycle after it is issued
            mem_raddr = scan_addr_ff[AddrW-1:0];
            if (hit) begin
               pend_in = 1'b0;
               res_in.index_out = byte_ff ? INDEX_OUT_W'(hit_idx[7:0])
                                          : hit_idx[INDEX_OUT_W-1:0];
               state_in = ST_DONE;
            end else if (issue) begin
               pend_in      = 1'b1;
               pend_addr_in = scan_addr_ff[AddrW-1:0];
               scan_addr_in = scan_addr_ff + 1'b1;
            end else begin
               pend_in       = 1'b0;
               res_in.status = STATUS_MISS;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         count_ff      <= '0;
         clear_addr_ff <= '0;
         pend_ff       <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         clear_addr_ff <= clear_addr_in;
         pend_ff       <= pend_in;
      end
      scan_addr_ff <= scan_addr_in;
      pend_addr_ff <= pend_addr_in;
      key_ff       <= key_in;
      mask_ff      <= mask_in;
      byte_ff      <= byte_in;
      res_ff       <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_DONE);
   assign res_data  = res_ff;

   `UTF8CT_ASSERT_SAME(a_we_source, clock, reset, mem_we, (state_ff == ST_CLEAR) || (req_valid && req_ready && (req_data.req_type == REQ_WRITE)), "table write outside clear or write request")
   `UTF8CT_ASSERT_NEXT(a_single_accept, clock, reset, req_valid && req_ready, !req_ready, "request taken while previous one still in progress")
   `UTF8CT_ASSERT_NEXT(a_count_grows, clock, reset, 1'b1, count_ff >= $past(count_ff), "entry count went down")

endmodule

// ----- rtl/utf8_code_table_reverse_lookup_core.sv -----
// top level of the utf8 code table with reverse lookup
// The table holds TABLE_SIZE utf8 characters in one synchronous ram. After
// reset a clearing pass zeroes the ram, one entry a cycle, so req_ready stays
// low until every entry is cleared. Each request then runs alone. A reverse
// lookup goes through the single ram read port, which the scan walks one entry
// per cycle from index 0 until the first hit, or to a miss after the first
// min(entry count, TABLE_SIZE) entries.
// A result register on the response side lets the next request be taken
// while an earlier result still waits for rsp_ready.
`timescale 1ns / 1ps

module utf8_code_table_reverse_lookup_core
   import utf8ct_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_data
);

   localparam int AddrW = $clog2(TABLE_SIZE);

   // ram port signals
   logic              mem_we;
   logic [AddrW-1:0]  mem_waddr;
   logic [CHAR_W-1:0] mem_wdata;
   logic [AddrW-1:0]  mem_raddr;
   logic [CHAR_W-1:0] mem_rdata;

   // finished result from the sequencer
   logic         res_valid;
   rsp_item_type res_data;
   logic         out_free;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff, rsp_data_in;

   utf8ct_ram #(
      .WIDTH(CHAR_W),
      .DEPTH(TABLE_SIZE)
   ) u_table (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   utf8ct_ctrl #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .out_free (out_free),
      .res_valid(res_valid),
      .res_data (res_data),
      .mem_we   (mem_we),
      .mem_waddr(mem_waddr),
      .mem_wdata(mem_wdata),
      .mem_raddr(mem_raddr),
      .mem_rdata(mem_rdata)
   );

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (res_valid && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the utf8 code table with reverse lookup
`timescale 1ns / 1ps

module tb_top;
   import utf8ct_pkg::*;

   // generous bound: clearing pass plus every request scanning the whole table
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int RANDOM_ITEMS    = 125;
   // last stretch of the random part runs with no idling on either side
   localparam int QUIET_TAIL      = 25;
   // long response hold-off, started once this many requests are in
   localparam int HOLD_OFF_AT     = 50;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_CYCLES    = 16;
   localparam int REPORT_MAX      = 10;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_item_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_item_type rsp_data;

   bit quiet_tail = 1'b0;
   bit held_off   = 1'b0;
   int cycles     = 0;

   // shadow of the character table: predicts one result per accepted request
   class code_table_board;
      logic [CHAR_W-1:0]  entries [TABLE_SIZE_DEF];
      logic [COUNT_W-1:0] entry_count;
      rsp_item_type       awaited_q[$];
      int                 accepted;
      int                 mismatches;

      function new();
         foreach (entries[i]) entries[i] = '0;
         entry_count = '0;
         accepted    = 0;
         mismatches  = 0;
      endfunction

      // bytes of the sequence that the lead byte implies, as a mask
      function logic [CHAR_W-1:0] seq_mask(logic [7:0] lead);
         int nbytes;
         nbytes = (lead < ONE_BYTE_LIMIT) ? 1 : (lead < TWO_BYTE_LIMIT) ? 2 :
                  (lead < THREE_BYTE_LIMIT) ? 3 : 4;
         return CHAR_W'((64'd1 << (8 * nbytes)) - 64'd1);
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type      res;
         logic [CHAR_W-1:0] m;
         int                bound;
         bit                hit;
         res = '0;
         m   = seq_mask(r.char_bytes[7:0]);
         hit = 1'b0;
         accepted++;
         case (r.req_type)
            REQ_WRITE: begin
               if (r.index >= TABLE_SIZE_DEF) begin
                  res.status = STATUS_RANGE;
               end else begin
                  entries[r.index] = r.char_bytes & m;
                  if (entry_count != COUNT_MAX) entry_count++;
               end
            end
            REQ_READ: begin
               if (r.index >= TABLE_SIZE_DEF) res.status = STATUS_RANGE;
               else res.char_out = entries[r.index];
            end
            default: begin
               bound = (entry_count > TABLE_SIZE_DEF) ? TABLE_SIZE_DEF : int'(entry_count);
               for (int i = 0; i < bound && !hit; i++) begin
                  if ((entries[i] & m) == (r.char_bytes & m)) begin
                     hit = 1'b1;
                     res.index_out = (r.req_type == REQ_LOOKUP_BYTE) ?
                                     INDEX_OUT_W'(i & 'hff) : INDEX_OUT_W'(i);
                  end
               end
               if (!hit) res.status = STATUS_MISS;
            end
         endcase
         awaited_q.push_back(res);
      endfunction

      function void report(string what, rsp_item_type want, rsp_item_type got);
         mismatches++;
         if (mismatches <= REPORT_MAX)
            $display("%s: expected status %0d index %0d char %h, got status %0d index %0d char %h",
                     what, want.status, want.index_out, want.char_out,
                     got.status, got.index_out, got.char_out);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         if (awaited_q.size() == 0) begin
            report("response with nothing outstanding", '0, got);
            return;
         end
         want = awaited_q.pop_front();
         if (got.status !== want.status || got.index_out !== want.index_out ||
             got.char_out !== want.char_out)
            report("response mismatch", want, got);
      endfunction
   endclass

   code_table_board board = new();

   utf8_code_table_reverse_lookup_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // random utf8 character: lead byte from one of the four length classes,
   // the remaining bytes fully random so the stored masking gets exercised
   function automatic logic [CHAR_W-1:0] rand_char();
      logic [CHAR_W-1:0] v;
      v = $urandom();
      case ($urandom_range(0, 3))
         0:       v[7:0] = 8'($urandom_range(0, 127));
         1:       v[7:0] = 8'($urandom_range(128, 223));
         2:       v[7:0] = 8'($urandom_range(224, 239));
         default: v[7:0] = 8'($urandom_range(240, 255));
      endcase
      return v;
   endfunction

   // offer one request and hold it until accepted; valid is left high so a
   // back-to-back request never lowers and raises it in the same step
   task automatic send_request(input logic [1:0] kind, input logic [INDEX_W-1:0] idx,
                               input logic [CHAR_W-1:0] chars);
      req_item_type item;
      item.req_type   = kind;
      item.index      = idx;
      item.char_bytes = chars;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
   endtask

   // response side: random stalls, plus one long hold-off so the block
   // backs up and has to drop req_ready while requests keep coming
   initial begin
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (!held_off && board.accepted >= HOLD_OFF_AT) begin
            held_off = 1'b1;
            rsp_ready <= 1'b0;
            for (int n = 0; n < HOLD_OFF_CYCLES; n++) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // every accepted response is checked against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_data);
   end

   // watchdog
   always @(posedge clock) begin
      cycles = cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("utf8_code_table_reverse_lookup_core test failed");
         $finish;
      end
   end

   initial begin
      logic [CHAR_W-1:0]  written_q[$];
      logic [CHAR_W-1:0]  ch;
      logic [CHAR_W-1:0]  m;
      logic [INDEX_W-1:0] idx;
      logic [1:0]         kind;
      int                 pick;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // reads of cleared entries at both ends of the table
      send_request(REQ_READ, 16'd0, 32'hffff_ffff);
      send_request(REQ_READ, 16'd4095, 32'h0);
      // lookups on an empty table must miss
      send_request(REQ_LOOKUP, 16'hffff, 32'h0);
      send_request(REQ_LOOKUP_BYTE, 16'h0, 32'h0000_0041);
      // writes at every length boundary, upper bytes should be dropped
      send_request(REQ_WRITE, 16'd0, 32'hffff_ff7f);
      send_request(REQ_WRITE, 16'd1, 32'h5a5a_a580);
      send_request(REQ_WRITE, 16'd2, 32'hffff_ffdf);
      send_request(REQ_WRITE, 16'd3, 32'hffa5_5ae0);
      send_request(REQ_WRITE, 16'd4, 32'hffff_ffef);
      send_request(REQ_WRITE, 16'd5, 32'h1234_56f0);
      send_request(REQ_WRITE, 16'd4095, 32'hffff_ffff);
      // out of range writes and reads
      send_request(REQ_WRITE, 16'd4096, 32'hdead_beef);
      send_request(REQ_WRITE, 16'hffff, 32'h0);
      send_request(REQ_READ, 16'd4096, 32'h0);
      send_request(REQ_READ, 16'hffff, 32'h0);
      // read back the last entry and a masked two byte entry
      send_request(REQ_READ, 16'd4095, 32'h0);
      send_request(REQ_READ, 16'd1, 32'h0);
      // hits, three of them with junk above the sequence length in the query
      send_request(REQ_LOOKUP, 16'd0, 32'h1234_567f);
      send_request(REQ_LOOKUP, 16'd0, 32'h9999_a580);
      send_request(REQ_LOOKUP_BYTE, 16'd0, 32'h1234_56f0);
      send_request(REQ_LOOKUP, 16'd0, 32'h77a5_5ae0);
      // entry 4095 lies beyond the entry count, so this one misses
      send_request(REQ_LOOKUP, 16'd0, 32'hffff_ffff);
      // a zero key hits the first never-written entry under the count
      send_request(REQ_LOOKUP, 16'd0, 32'h0);

      // --- random part ---
      // mostly writes to a small window followed by lookups of what was
      // written, so the scan finds hits at varied depths; the rest is noise
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - QUIET_TAIL) quiet_tail = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            kind = REQ_WRITE;
            if (pick < 4) idx = 16'($urandom());
            else if (pick < 8) idx = 16'($urandom_range(0, TABLE_SIZE_DEF - 1));
            else idx = 16'($urandom_range(0, 47));
            ch = rand_char();
            written_q.push_back(ch);
         end else if (pick < 50) begin
            kind = REQ_READ;
            idx  = (pick < 42) ? 16'($urandom_range(0, 63)) : 16'($urandom());
            ch   = $urandom();
         end else if (pick < 90) begin
            kind = ($urandom_range(0, 2) == 0) ? REQ_LOOKUP_BYTE : REQ_LOOKUP;
            idx  = 16'($urandom());
            if (written_q.size() != 0 && $urandom_range(0, 3) != 0) begin
               // reuse a written character, scrambling the bytes beyond its length
               ch = written_q[$urandom_range(0, written_q.size() - 1)];
               m  = board.seq_mask(ch[7:0]);
               ch = (ch & m) | (32'($urandom()) & ~m);
            end else begin
               ch = rand_char();
            end
         end else begin
            kind = 2'($urandom_range(0, 3));
            idx  = 16'($urandom());
            ch   = $urandom();
         end
         send_request(kind, idx, ch);
      end
      req_valid <= 1'b0;

      // drain everything outstanding, then a short settle
      while (board.awaited_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.mismatches == 0 && board.awaited_q.size() == 0) begin
         $display("utf8_code_table_reverse_lookup_core test passed");
      end else begin
         $display("utf8_code_table_reverse_lookup_core test failed");
      end
      $finish;
   end

endmodule
